@@ rtl/core/ffa_pkg.sv @@
// Package for the first-fit frame allocator: sizes, commands, process states.
// No dependencies.
`default_nettype none
package ffa_pkg;
  localparam int FRAMES = 64;
  localparam int MAX_PROCS = 64;
  localparam int FW = $clog2(FRAMES);
  localparam int PW = $clog2(MAX_PROCS);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_DEALLOC = 2'd1,
    CMD_SETST = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OTHER = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_PROC = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_RES,
    S_PLACE,
    S_FILL,
    S_FIND,
    S_FREE,
    S_SET,
    S_STAT,
    S_FRAG,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

@@ rtl/core/ffa_frame_ram.sv @@
// Frame table memory: used mark and owner per frame, registered read.
// Depends on ffa_pkg.
`default_nettype none
module ffa_frame_ram (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ffa_pkg::FW-1:0] waddr,
  input  wire logic                 wused,
  input  wire logic [ffa_pkg::PW-1:0] wowner,
  input  wire logic [ffa_pkg::FW-1:0] raddr,
  output logic                      rused,
  output logic [ffa_pkg::PW-1:0]    rowner
);
  import ffa_pkg::*;
  logic [PW:0] mem [FRAMES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wused, wowner};
    {rused, rowner} <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/first_fit_frame_allocator.sv @@
// Top level of the first-fit frame allocator: sequencer, process table, totals.
// Depends on ffa_pkg and ffa_frame_ram.
// Sequence: every request ends with a fragmentation pass over the frame table; free adds
// a freeing pass, allocate a residency pass, then a placement pass and a fill if not resident,
// and each eviction a search pass and a freeing pass before placement is tried again.
// Throughput: one request at a time, the next taken the cycle after the result is taken.
// Reset: clearing pass over the frame and process memories, no request taken.
`default_nettype none
module first_fit_frame_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [5:0]  process_id,
  input  wire logic [6:0]  page_count,
  input  wire logic [1:0]  new_state,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [5:0]       start_frame,
  output logic [6:0]       evicted_count,
  output logic [31:0]      pages_in_total,
  output logic [31:0]      pages_out_total,
  output logic [22:0]      inactive_kb
);
  import ffa_pkg::*;

  state_t state, state_next;
  logic [16:0] frame_size_kb;
  cmd_t r_cmd;
  logic [PW-1:0] r_pid;
  logic [6:0] r_need;
  logic [1:0] r_ns;
  logic [FW:0] scan, scan_next;
  logic [FW:0] rd_idx;
  logic rd_v;
  logic [FW-1:0] raddr;
  logic rused;
  logic [PW-1:0] rowner;
  logic we;
  logic [FW-1:0] waddr;
  logic wused;
  logic [PW-1:0] wowner;
  logic [8:0] pmem [MAX_PROCS];
  logic [PW-1:0] paddr;
  logic p_we;
  logic [8:0] p_wdata;
  logic [1:0] p_stat;
  logic [6:0] p_pages;
  logic p_v, p_used;
  logic [FW:0] p_idx;
  logic [PW-1:0] p_owner;
  logic [6:0] run;
  logic [FW-1:0] first;
  logic found;
  logic [PW-1:0] free_pid;
  logic [FW:0] f_first, f_last, f_cnt;
  logic f_any;
  logic [31:0] pin, pout;
  logic [FW:0] fill_end;
  logic scanning, last_rd, hit, free_hit, fit_now, ready_hit, p_last;

  ffa_frame_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wused(wused), .wowner(wowner),
    .raddr(raddr), .rused(rused), .rowner(rowner)
  );

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [6:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {26'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign scanning = (state == S_RES) || (state == S_PLACE) || (state == S_FIND) ||
                    (state == S_FREE) || (state == S_FRAG);
  assign raddr = scan[FW-1:0];
  assign in_ready = (state == S_IDLE);

  assign last_rd = rd_v && (rd_idx == (FW+1)'(FRAMES - 1));
  assign hit = rd_v && rused && (rowner == r_pid);
  assign free_hit = rd_v && rused && (rowner == free_pid);
  assign fit_now = rd_v && !rused && (run + 1'b1 == r_need);
  // process entry looked up by the owner the frame read returns, its data the cycle after
  assign ready_hit = p_v && p_used && (p_stat == ST_READY);
  assign p_last = p_v && (p_idx == (FW+1)'(FRAMES - 1));

  // process table: status and page count per process
  always_ff @(posedge clk) begin
    if (p_we) pmem[paddr] <= p_wdata;
    {p_stat, p_pages} <= pmem[paddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      scan <= '0;
    end else begin
      state <= state_next;
      scan <= scan_next;
    end
  end

  always_comb begin
    state_next = state;
    scan_next = scan;
    we = 1'b0;
    waddr = rd_idx[FW-1:0];
    wused = 1'b0;
    wowner = '0;
    p_we = 1'b0;
    p_wdata = {p_stat, p_pages};
    paddr = r_pid;
    if (scanning && scan < (FW+1)'(FRAMES)) scan_next = scan + 1'b1;
    case (state)
      S_CLR: begin
        we = 1'b1;
        waddr = scan[FW-1:0];
        p_we = 1'b1;
        p_wdata = {ST_OTHER, 7'd0};
        paddr = scan[PW-1:0];
        scan_next = scan + 1'b1;
        if (scan == (FW+1)'(FRAMES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        paddr = process_id;
        if (in_valid) begin
          scan_next = '0;
          case (cmd_t'(cmd))
            CMD_ALLOC: state_next = S_RES;
            CMD_DEALLOC: state_next = S_FREE;
            CMD_SETST: state_next = S_SET;
            default: state_next = S_STAT;
          endcase
        end
      end
      S_SET: begin
        p_we = 1'b1;
        p_wdata = {(r_ns > ST_PROC) ? ST_OTHER : r_ns, p_pages};
        state_next = S_STAT;
      end
      S_RES: begin
        if (last_rd) begin
          scan_next = '0;
          if (found || hit) begin
            p_we = 1'b1;
            p_wdata = {ST_PROC, p_pages};
            state_next = S_STAT;
          end else if (r_need == 7'd0) begin
            p_we = 1'b1;
            p_wdata = {ST_PROC, 7'd0};
            state_next = S_STAT;
          end else begin
            state_next = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        if (fit_now) begin
          scan_next = (run == 7'd0) ? rd_idx : {1'b0, first};
          state_next = S_FILL;
        end else if (last_rd) begin
          scan_next = '0;
          state_next = S_FIND;
        end
      end
      S_FILL: begin
        we = 1'b1;
        waddr = scan[FW-1:0];
        wused = 1'b1;
        wowner = r_pid;
        scan_next = scan + 1'b1;
        if (scan == fill_end) begin
          p_we = 1'b1;
          p_wdata = {ST_PROC, r_need};
          state_next = S_STAT;
        end
      end
      S_FIND: begin
        paddr = rowner;
        if (ready_hit) begin
          scan_next = '0;
          state_next = S_FREE;
        end else if (p_last) begin
          state_next = S_STAT;
        end
      end
      S_FREE: begin
        we = free_hit;
        if (last_rd) begin
          scan_next = '0;
          state_next = (r_cmd == CMD_ALLOC) ? S_PLACE : S_STAT;
        end
      end
      S_STAT: begin
        scan_next = '0;
        state_next = S_FRAG;
      end
      S_FRAG: begin
        if (last_rd) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_valid && out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      p_v <= 1'b0;
      frame_size_kb <= 17'd16;
      out_valid <= 1'b0;
      pin <= '0;
      pout <= '0;
    end else begin
      if (cfg_we) frame_size_kb <= cfg_wdata;
      // a read issued in the cycle a pass ends is dropped
      rd_v <= scanning && (state_next == state) && (scan < (FW+1)'(FRAMES));
      rd_idx <= scan;
      p_v <= rd_v && (state == S_FIND) && (state_next == S_FIND);
      p_used <= rused;
      p_idx <= rd_idx;
      p_owner <= rowner;
      if (state != S_PLACE) run <= '0;
      else if (rd_v) run <= rused ? 7'd0 : run + 1'b1;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_cmd <= cmd_t'(cmd);
            r_pid <= process_id;
            r_need <= page_count;
            r_ns <= new_state;
            ok <= 1'b1;
            start_frame <= '0;
            evicted_count <= '0;
            found <= 1'b0;
            free_pid <= process_id;
          end
        end
        S_RES: begin
          if (hit) found <= 1'b1;
        end
        S_PLACE: begin
          if (rd_v && !rused) begin
            if (run == 7'd0) first <= rd_idx[FW-1:0];
            if (fit_now) begin
              start_frame <= (run == 7'd0) ? rd_idx[FW-1:0] : first;
              fill_end <= rd_idx;
            end
          end
        end
        S_FILL: begin
          if (scan == fill_end) pin <= sat_add(pin, r_need);
        end
        S_FIND: begin
          if (ready_hit) begin
            free_pid <= p_owner;
            pout <= sat_add(pout, p_pages);
            if (evicted_count != 7'd127) evicted_count <= evicted_count + 1'b1;
          end else if (p_last) begin
            ok <= 1'b0;
          end
        end
        S_FREE: begin
          if (last_rd && r_cmd == CMD_DEALLOC) pout <= sat_add(pout, p_pages);
        end
        S_STAT: begin
          f_any <= 1'b0;
          f_cnt <= '0;
          f_first <= '0;
          f_last <= '0;
        end
        S_FRAG: begin
          if (rd_v && rused) begin
            if (!f_any) f_first <= rd_idx;
            f_any <= 1'b1;
            f_last <= rd_idx;
            f_cnt <= f_cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            pages_in_total <= pin;
            pages_out_total <= pout;
            begin : frag
              logic [FW:0] gaps;
              logic [FW+17:0] kb;
              gaps = f_any ? (f_last - f_first + 1'b1 - f_cnt) : '0;
              kb = gaps * frame_size_kb;
              inactive_kb <= (kb > (FW+18)'(23'h7FFFFF)) ? 23'h7FFFFF : kb[22:0];
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_one_req: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("request taken while result pending");
  a_fill_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (r_need != 7'd0))
    else $error("fill with zero pages");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(pages_in_total))
    else $error("result dropped");
endmodule
`default_nettype wire

@@ verif/first_fit_frame_allocator_tb.sv @@
// Testbench for first_fit_frame_allocator: directed and random allocate, free, state and
// no-op requests, checked against an in-bench frame table predictor.
// Depends on ffa_pkg and the allocator RTL.
`timescale 1ns / 100ps
module first_fit_frame_allocator_tb;
  import ffa_pkg::*;

  typedef struct packed {
    bit        ok;
    bit [5:0]  start;
    bit [6:0]  evicted;
    bit [31:0] pin;
    bit [31:0] pout;
    bit [22:0] ikb;
  } alloc_result_t;

  class alloc_scoreboard;
    alloc_result_t pending[$];
    bit [5:0]  owner[64];
    bit        used[64];
    bit [1:0]  status[64];
    bit [6:0]  pages[64];
    bit [31:0] pin_total, pout_total;
    bit [16:0] frame_kb = 17'd16;
    int        errors;

    function bit [31:0] sat_add(bit [31:0] a, bit [6:0] b);
      bit [32:0] s;
      s = a + b;
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void free_frames(int pid);
      for (int i = 0; i < 64; i++) begin
        if (used[i] && owner[i] == pid) begin
          used[i] = 0;
          owner[i] = 0;
        end
      end
    endfunction

    function bit resident(int pid);
      for (int i = 0; i < 64; i++) if (used[i] && owner[i] == pid) return 1;
      return 0;
    endfunction

    function bit fit(int pid, int need, output int start);
      int run, first;
      run = 0;
      first = 0;
      start = 0;
      if (need != 0) begin
        for (int i = 0; i < 64; i++) begin
          if (!used[i]) begin
            if (run == 0) first = i;
            run++;
            if (run == need) break;
          end else run = 0;
        end
        if (run < need) return 0;
        for (int i = first; i < first + need; i++) begin
          used[i] = 1;
          owner[i] = 6'(pid);
        end
        start = first;
      end
      pages[pid] = 7'(need);
      pin_total = sat_add(pin_total, 7'(need));
      status[pid] = ST_PROC;
      return 1;
    endfunction

    function int ready_owner();
      for (int i = 0; i < 64; i++) if (used[i] && status[owner[i]] == ST_READY) return owner[i];
      return -1;
    endfunction

    function bit [22:0] gap_kb();
      int first, last, gaps;
      longint kb;
      first = 64;
      last = 0;
      gaps = 0;
      for (int i = 0; i < 64; i++) begin
        if (used[i]) begin
          if (first == 64) first = i;
          last = i;
        end
      end
      if (first == 64) return 0;
      for (int i = first; i <= last; i++) if (!used[i]) gaps++;
      kb = longint'(gaps) * frame_kb;
      return (kb > 64'h7F_FFFF) ? 23'h7F_FFFF : kb[22:0];
    endfunction

    function void note_request(cmd_t c, bit [5:0] pid, bit [6:0] need, bit [1:0] ns);
      alloc_result_t r;
      int start, victim;
      r = '0;
      r.ok = 1;
      start = 0;
      case (c)
        CMD_ALLOC: begin
          if (resident(pid)) status[pid] = ST_PROC;
          else if (!fit(pid, need, start)) begin
            r.ok = 0;
            forever begin
              victim = ready_owner();
              if (victim < 0) break;
              free_frames(victim);
              pout_total = sat_add(pout_total, pages[victim]);
              if (r.evicted < 7'd127) r.evicted++;
              if (fit(pid, need, start)) begin
                r.ok = 1;
                break;
              end
            end
          end
        end
        CMD_DEALLOC: begin
          free_frames(pid);
          pout_total = sat_add(pout_total, pages[pid]);
        end
        CMD_SETST: status[pid] = (ns == 2'd3) ? ST_OTHER : ns;
        default: ;
      endcase
      r.start = start[5:0];
      r.pin = pin_total;
      r.pout = pout_total;
      r.ikb = gap_kb();
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.ok != exp.ok) begin
        $error("ok: expected %0d, got %0d", exp.ok, got.ok); errors++;
      end
      if (got.start != exp.start) begin
        $error("start_frame: expected %0d, got %0d", exp.start, got.start); errors++;
      end
      if (got.evicted != exp.evicted) begin
        $error("evicted_count: expected %0d, got %0d", exp.evicted, got.evicted); errors++;
      end
      if (got.pin != exp.pin) begin
        $error("pages_in_total: expected %0d, got %0d", exp.pin, got.pin); errors++;
      end
      if (got.pout != exp.pout) begin
        $error("pages_out_total: expected %0d, got %0d", exp.pout, got.pout); errors++;
      end
      if (got.ikb != exp.ikb) begin
        $error("inactive_kb: expected %0d, got %0d", exp.ikb, got.ikb); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = '0;
  logic [5:0]  process_id = '0;
  logic [6:0]  page_count = '0;
  logic [1:0]  new_state = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [5:0]  start_frame;
  logic [6:0]  evicted_count;
  logic [31:0] pages_in_total, pages_out_total;
  logic [22:0] inactive_kb;

  alloc_scoreboard sb = new();
  int tx_idle_pct = 31;
  int rx_idle_pct = 74;
  int stall_cycles = 0;
  localparam int STALL_LIMIT = 200000;

  first_fit_frame_allocator u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .process_id(process_id),
    .page_count(page_count), .new_state(new_state), .out_valid(out_valid),
    .out_ready(out_ready), .ok(ok), .start_frame(start_frame),
    .evicted_count(evicted_count), .pages_in_total(pages_in_total),
    .pages_out_total(pages_out_total), .inactive_kb(inactive_kb)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(cmd_t'(cmd), process_id, page_count, new_state);
      if (out_valid && out_ready)
        sb.check_result({ok, start_frame, evicted_count, pages_in_total, pages_out_total,
                         inactive_kb});
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_req(cmd_t c, bit [5:0] pid, bit [6:0] need, bit [1:0] ns);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    process_id <= pid;
    page_count <= need;
    new_state <= ns;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_frame_kb(bit [16:0] kb);
    cfg_we <= 1'b1;
    cfg_wdata <= kb;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.frame_kb = kb;
  endtask

  task automatic random_req();
    int r;
    bit [5:0] pid;
    bit [6:0] need;
    r = $urandom_range(99);
    pid = $urandom_range(1) ? 6'($urandom_range(63)) : 6'($urandom_range(11));
    if (r < 45) begin
      r = $urandom_range(99);
      if (r < 88) need = 7'($urandom_range(10, 1));
      else if (r < 97) need = 7'($urandom_range(40, 11));
      else need = $urandom_range(1) ? 7'd64 : 7'd0;
      send_req(CMD_ALLOC, pid, need, 2'($urandom_range(3)));
    end else if (r < 72) begin
      send_req(CMD_SETST, pid, 7'($urandom_range(127)),
               $urandom_range(2) != 0 ? ST_READY : 2'($urandom_range(3)));
    end else if (r < 92) begin
      send_req(CMD_DEALLOC, pid, 7'($urandom_range(64)), 2'($urandom_range(3)));
    end else begin
      send_req(CMD_NOP, pid, 7'($urandom_range(64)), 2'($urandom_range(3)));
    end
  endtask

  initial begin
    bit [16:0] kb_set[3];
    kb_set[0] = 17'd65536;
    kb_set[1] = 17'd1;
    kb_set[2] = 17'($urandom_range(65536, 2));
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: zero pages, full table, resident, unfit, evictions, odd codes
    send_req(CMD_ALLOC, 6'd5, 7'd0, ST_OTHER);
    send_req(CMD_ALLOC, 6'd63, 7'd64, ST_OTHER);
    send_req(CMD_ALLOC, 6'd63, 7'd3, ST_OTHER);
    send_req(CMD_ALLOC, 6'd1, 7'd1, ST_OTHER);
    send_req(CMD_SETST, 6'd63, 7'd0, ST_READY);
    send_req(CMD_ALLOC, 6'd1, 7'd1, ST_OTHER);
    send_req(CMD_DEALLOC, 6'd63, 7'd0, ST_OTHER);
    send_req(CMD_DEALLOC, 6'd1, 7'd0, ST_OTHER);
    send_req(CMD_ALLOC, 6'd1, 7'd32, ST_OTHER);
    send_req(CMD_ALLOC, 6'd2, 7'd32, ST_OTHER);
    send_req(CMD_SETST, 6'd1, 7'd0, ST_READY);
    send_req(CMD_SETST, 6'd2, 7'd0, 2'd3);
    send_req(CMD_ALLOC, 6'd3, 7'd10, ST_OTHER);
    send_req(CMD_ALLOC, 6'd4, 7'd40, ST_OTHER);
    send_req(CMD_SETST, 6'd4, 7'd127, ST_PROC);
    send_req(CMD_SETST, 6'd0, 7'd0, ST_OTHER);
    send_req(CMD_NOP, 6'd63, 7'd64, 2'd3);
    send_req(CMD_DEALLOC, 6'd3, 7'd0, ST_OTHER);
    send_req(CMD_ALLOC, 6'd0, 7'd1, ST_OTHER);
    send_req(CMD_ALLOC, 6'd7, 7'd2, ST_OTHER);
    send_req(CMD_ALLOC, 6'd8, 7'd1, ST_OTHER);
    send_req(CMD_DEALLOC, 6'd7, 7'd0, ST_OTHER);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 74 : 0;
      rx_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 31 : 0;
      write_frame_kb(kb_set[ph]);
      for (int i = 0; i < 230; i++) begin
        random_req();
        if (i % 97 == 50) drain();
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
